// ===== rtl/core/accel_moving_average_direction_unit_assert.svh =====
// Assertion macros for the port checker file.
// Both sample on clk and hold off while arst_n is low.
`ifndef ACCEL_MOVING_AVERAGE_DIRECTION_UNIT_ASSERT_SVH
`define ACCEL_MOVING_AVERAGE_DIRECTION_UNIT_ASSERT_SVH

// Same-cycle implication
`define AMAD_ASSERT_NOW(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed in %m");

// Next-cycle implication
`define AMAD_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed in %m");

`endif

// ===== rtl/core/amad_pkg.sv =====
`timescale 1ns / 1ps

package amad_pkg;

	// Register and output widths
	localparam int WL_BITS  = 8;
	localparam logic [WL_BITS-1:0] WL_RESET = 8'd5;
	localparam int DIR_BITS = 16;

	// Normalized magnitude lies in [2^(NORM_BITS-1), 2^NORM_BITS)
	localparam int NORM_BITS = 30;
	// Quotient bits per axis (result up to 16384)
	localparam int DIV_STEPS = 15;
	// Step counter inside the normalizer
	localparam int CNT_BITS  = 5;

	// Normalizer result, held until the next start
	typedef struct packed {
		logic                          done;
		logic                          zero;
		logic [2:0][DIR_BITS-1:0]      dir;
	} nrm_res_t;

endpackage

// ===== rtl/core/accel_moving_average_direction_unit.sv =====
`timescale 1ns / 1ps

// Channel  Handshake            Beat contents
// cfg      cfg_valid/cfg_ready  window_len
// in       in_valid/in_ready    accel_x, accel_y, accel_z
// out      out_valid/out_ready  dir_x, dir_y, dir_z, zero_vector
//
// One item at a time: no new sample is taken while the last one is being averaged or
// normalized. History is read one ring entry per cycle from the single ring read port;
// square root and divides run one bit per cycle.
// Reset: window_len 5, history unprimed, no output pending; the ring has no reset.
// A finished result waits in the output register, which frees the input side.
module accel_moving_average_direction_unit import amad_pkg::*; #(
	parameter int MAX_WINDOW  = 128,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [WL_BITS-1:0]            window_len,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] accel_x,
	input  logic signed [SAMPLE_BITS-1:0] accel_y,
	input  logic signed [SAMPLE_BITS-1:0] accel_z,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [DIR_BITS-1:0]    dir_x,
	output logic signed [DIR_BITS-1:0]    dir_y,
	output logic signed [DIR_BITS-1:0]    dir_z,
	output logic                          zero_vector
);

	localparam int AW = $clog2(MAX_WINDOW);
	localparam int FW = $clog2(MAX_WINDOW + 1);
	localparam int SW = SAMPLE_BITS + AW + 1;
	localparam int CW = (AW + 1 > WL_BITS + 1) ? AW + 1 : WL_BITS + 1;
	localparam int RW = 3 * SAMPLE_BITS;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_ACC  = 2'd1;
	localparam logic [1:0] ST_NORM = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [RW-1:0]          ring_q [MAX_WINDOW];
	logic [1:0]             state_q;
	logic [WL_BITS-1:0]     wl_q;
	logic                   primed_q;
	logic [FW-1:0]          fill_q;
	logic [AW-1:0]          wp_q;
	logic [AW-1:0]          rd_ptr_q;
	logic [AW-1:0]          nring_q;
	logic [AW-1:0]          nprime_q;
	logic                   acc_vld_s1;
	logic                   acc_ring_s1;
	logic [RW-1:0]          rd_data_s1;
	logic [RW-1:0]          prime_q;
	logic [2:0][SW-1:0]     sum_q;
	logic                   out_valid_q;
	logic [2:0][DIR_BITS-1:0] dir_q;
	logic                   zero_q;

	logic [RW-1:0]          smp;
	logic [RW-1:0]          add_op;
	logic                   accept;
	logic [AW-1:0]          wm1;
	logic [FW-1:0]          fpre;
	logic [AW-1:0]          nring_new;
	logic                   issue_ring;
	logic                   issue_prime;
	logic                   norm_go;
	logic                   out_load;
	nrm_res_t               nres;

	assign smp       = {accel_z, accel_y, accel_x};
	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;

	// Effective window minus one, and how much of it comes from the ring
	always_comb begin
		if (wl_q == '0) begin
			wm1 = '0;
		end else if (CW'(wl_q) > CW'(MAX_WINDOW)) begin
			wm1 = AW'(MAX_WINDOW - 1);
		end else begin
			wm1 = AW'(CW'(wl_q) - CW'(1));
		end
		fpre      = primed_q ? fill_q : '0;
		nring_new = (fpre < FW'(wm1)) ? AW'(fpre) : wm1;
	end

	assign issue_ring  = (state_q == ST_ACC) && (nring_q != '0);
	assign issue_prime = (state_q == ST_ACC) && (nring_q == '0) && (nprime_q != '0);
	assign norm_go     = (state_q == ST_ACC) && (nring_q == '0) && (nprime_q == '0)
	                     && !acc_vld_s1;
	assign out_load    = (state_q == ST_OUT) && (!out_valid_q || out_ready);
	assign add_op      = acc_ring_s1 ? rd_data_s1 : prime_q;

	// Sample ring: write at accept, one registered read per cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			ring_q[wp_q] <= smp;
		end
		rd_data_s1 <= ring_q[rd_ptr_q];
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wl_q        <= WL_RESET;
			primed_q    <= 1'b0;
			fill_q      <= '0;
			wp_q        <= '0;
			rd_ptr_q    <= '0;
			nring_q     <= '0;
			nprime_q    <= '0;
			acc_vld_s1  <= 1'b0;
			acc_ring_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			acc_vld_s1  <= issue_ring || issue_prime;
			acc_ring_s1 <= issue_ring;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						primed_q <= 1'b1;
						fill_q   <= (fpre == FW'(MAX_WINDOW)) ? fpre : fpre + 1'b1;
						wp_q     <= (wp_q == AW'(MAX_WINDOW - 1)) ? '0 : wp_q + 1'b1;
						rd_ptr_q <= (wp_q == '0) ? AW'(MAX_WINDOW - 1) : wp_q - 1'b1;
						nring_q  <= nring_new;
						nprime_q <= wm1 - nring_new;
						state_q  <= ST_ACC;
					end
				end
				ST_ACC: begin
					if (issue_ring) begin
						nring_q  <= nring_q - 1'b1;
						rd_ptr_q <= (rd_ptr_q == '0) ? AW'(MAX_WINDOW - 1)
						                             : rd_ptr_q - 1'b1;
					end else if (issue_prime) begin
						nprime_q <= nprime_q - 1'b1;
					end
					if (norm_go) begin
						state_q <= ST_NORM;
					end
				end
				ST_NORM: begin
					if (nres.done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// A register write re-arms priming
			if (cfg_valid && cfg_ready) begin
				wl_q     <= window_len;
				primed_q <= 1'b0;
			end

			// Output slot
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Window sums and priming sample
	always_ff @(posedge clk) begin
		if (accept) begin
			if (!primed_q) begin
				prime_q <= smp;
			end
			for (int i = 0; i < 3; i++) begin
				sum_q[i] <= SW'($signed(smp[i*SAMPLE_BITS +: SAMPLE_BITS]));
			end
		end else if (acc_vld_s1) begin
			for (int i = 0; i < 3; i++) begin
				sum_q[i] <= sum_q[i] + SW'($signed(add_op[i*SAMPLE_BITS +: SAMPLE_BITS]));
			end
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			dir_q  <= nres.dir;
			zero_q <= nres.zero;
		end
	end

	amad_norm #(
		.SUM_BITS (SW)
	) u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (norm_go),
		.sum_x  ($signed(sum_q[0])),
		.sum_y  ($signed(sum_q[1])),
		.sum_z  ($signed(sum_q[2])),
		.res    (nres)
	);

	assign out_valid   = out_valid_q;
	assign dir_x       = $signed(dir_q[0]);
	assign dir_y       = $signed(dir_q[1]);
	assign dir_z       = $signed(dir_q[2]);
	assign zero_vector = zero_q;

endmodule

// ===== rtl/core/amad_norm.sv =====
`timescale 1ns / 1ps

// Bit-serial normalizer: scale, sum of squares, square root, three divides.
module amad_norm import amad_pkg::*; #(
	parameter int SUM_BITS = 24
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       go,
	input  logic signed [SUM_BITS-1:0] sum_x,
	input  logic signed [SUM_BITS-1:0] sum_y,
	input  logic signed [SUM_BITS-1:0] sum_z,
	output nrm_res_t                   res
);

	localparam int NW = (SUM_BITS > NORM_BITS + 1) ? SUM_BITS : NORM_BITS + 1;
	localparam int MB = 2 * NORM_BITS + 2;	// sum of three squares
	localparam int RB = NORM_BITS + 1;	// root bits
	localparam int QB = DIV_STEPS;
	localparam int DB = RB + 1;		// divisor 2*r

	localparam logic [2:0] PH_IDLE  = 3'd0;
	localparam logic [2:0] PH_SHIFT = 3'd1;
	localparam logic [2:0] PH_SQR   = 3'd2;
	localparam logic [2:0] PH_ROOT  = 3'd3;
	localparam logic [2:0] PH_DINIT = 3'd4;
	localparam logic [2:0] PH_DIV   = 3'd5;
	localparam logic [2:0] PH_FIN   = 3'd6;

	logic [2:0]                 ph_q;
	logic [CNT_BITS-1:0]        cnt_q;
	logic [2:0]                 neg_q;
	logic [2:0][NW-1:0]         mag_q;
	logic [2:0][NORM_BITS-1:0]  mul_q;
	logic [MB-1:0]              acc_q;
	logic [RB+2:0]              rem_q;
	logic [RB-1:0]              root_q;
	logic [2:0][DB-1:0]         drem_q;
	logic [QB-1:0]              lo_q;
	logic [2:0][QB-1:0]         quo_q;
	logic                       done_q;
	logic                       zero_q;
	logic [2:0][DIR_BITS-1:0]   dir_q;

	logic signed [2:0][SUM_BITS-1:0] sum_in;
	logic [2:0][NW-1:0]         mag_in;
	logic                       all_zero;
	logic                       any_hi;
	logic                       any_top;
	logic [NORM_BITS+1:0]       pp;
	logic [RB+2:0]              rem_n;
	logic [RB+2:0]              trial;
	logic                       root_ge;
	logic [DB:0]                dvs;
	logic [2:0][DB:0]           dt;
	logic [2:0]                 div_ge;

	// Magnitudes of the incoming sums (sign-extended before negation)
	always_comb begin
		sum_in = {sum_z, sum_y, sum_x};
		for (int i = 0; i < 3; i++) begin
			mag_in[i] = sum_in[i][SUM_BITS-1] ? NW'(-(NW'($signed(sum_in[i]))))
			                                  : NW'(sum_in[i]);
		end
		all_zero = (sum_x == '0) && (sum_y == '0) && (sum_z == '0);
	end

	// Range tests for the scaling shift
	always_comb begin
		any_hi  = 1'b0;
		any_top = 1'b0;
		for (int i = 0; i < 3; i++) begin
			any_hi  = any_hi  | (|mag_q[i][NW-1:NORM_BITS]);
			any_top = any_top | (|mag_q[i][NW-1:NORM_BITS-1]);
		end
	end

	// Partial product row of the serial squarer
	always_comb begin
		pp = '0;
		for (int i = 0; i < 3; i++) begin
			if (mul_q[i][NORM_BITS-1]) begin
				pp = pp + (NORM_BITS+2)'(mag_q[i][NORM_BITS-1:0]);
			end
		end
	end

	// One root bit per cycle
	always_comb begin
		rem_n   = {rem_q[RB:0], acc_q[MB-1:MB-2]};
		trial   = {1'b0, root_q, 2'b01};
		root_ge = rem_n >= trial;
	end

	// One quotient bit per axis per cycle
	always_comb begin
		dvs = {1'b0, root_q, 1'b0};
		for (int i = 0; i < 3; i++) begin
			dt[i]     = {drem_q[i], lo_q[QB-1]};
			div_ge[i] = dt[i] >= dvs;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= PH_IDLE;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (ph_q)
				PH_IDLE: begin
					if (go) begin
						if (all_zero) begin
							done_q <= 1'b1;
						end else begin
							ph_q <= PH_SHIFT;
						end
					end
				end
				PH_SHIFT: begin
					if (!any_hi && any_top) begin
						ph_q  <= PH_SQR;
						cnt_q <= '0;
					end
				end
				PH_SQR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_BITS'(NORM_BITS - 1)) begin
						ph_q  <= PH_ROOT;
						cnt_q <= '0;
					end
				end
				PH_ROOT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_BITS'(RB - 1)) begin
						ph_q  <= PH_DINIT;
						cnt_q <= '0;
					end
				end
				PH_DINIT: begin
					ph_q <= PH_DIV;
				end
				PH_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_BITS'(QB - 1)) begin
						ph_q  <= PH_FIN;
						cnt_q <= '0;
					end
				end
				PH_FIN: begin
					done_q <= 1'b1;
					ph_q   <= PH_IDLE;
				end
				default: begin
					ph_q <= PH_IDLE;
				end
			endcase
		end
	end

	// Datapath shift registers
	always_ff @(posedge clk) begin
		case (ph_q)
			PH_IDLE: begin
				if (go) begin
					for (int i = 0; i < 3; i++) begin
						neg_q[i] <= sum_in[i][SUM_BITS-1];
						mag_q[i] <= mag_in[i];
					end
					if (all_zero) begin
						zero_q <= 1'b1;
						dir_q  <= '0;
					end
				end
			end
			PH_SHIFT: begin
				for (int i = 0; i < 3; i++) begin
					if (any_hi) begin
						mag_q[i] <= mag_q[i] >> 1;
					end else if (!any_top) begin
						mag_q[i] <= mag_q[i] << 1;
					end else begin
						mul_q[i] <= mag_q[i][NORM_BITS-1:0];
					end
				end
				acc_q  <= '0;
				rem_q  <= '0;
				root_q <= '0;
			end
			PH_SQR: begin
				acc_q <= {acc_q[MB-2:0], 1'b0} + MB'(pp);
				for (int i = 0; i < 3; i++) begin
					mul_q[i] <= mul_q[i] << 1;
				end
			end
			PH_ROOT: begin
				acc_q  <= acc_q << 2;
				rem_q  <= root_ge ? (rem_n - trial) : rem_n;
				root_q <= {root_q[RB-2:0], root_ge};
			end
			PH_DINIT: begin
				for (int i = 0; i < 3; i++) begin
					drem_q[i] <= DB'(mag_q[i][NORM_BITS-1:0]) + DB'(root_q[RB-1:QB]);
					quo_q[i]  <= '0;
				end
				lo_q <= root_q[QB-1:0];
			end
			PH_DIV: begin
				for (int i = 0; i < 3; i++) begin
					drem_q[i] <= div_ge[i] ? DB'(dt[i] - dvs) : DB'(dt[i]);
					quo_q[i]  <= {quo_q[i][QB-2:0], div_ge[i]};
				end
				lo_q <= lo_q << 1;
			end
			PH_FIN: begin
				zero_q <= 1'b0;
				for (int i = 0; i < 3; i++) begin
					dir_q[i] <= neg_q[i] ? (DIR_BITS'(0) - DIR_BITS'(quo_q[i]))
					                     : DIR_BITS'(quo_q[i]);
				end
			end
			default: begin
				zero_q <= zero_q;
			end
		endcase
	end

	assign res.done = done_q;
	assign res.zero = zero_q;
	assign res.dir  = dir_q;

endmodule

// ===== rtl/core/amad_chk.sv =====
`timescale 1ns / 1ps
`include "accel_moving_average_direction_unit_assert.svh"

// Port-level checks on the direction unit
module amad_chk import amad_pkg::*; (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic signed [DIR_BITS-1:0] dir_x,
	input logic signed [DIR_BITS-1:0] dir_y,
	input logic signed [DIR_BITS-1:0] dir_z,
	input logic                       zero_vector
);

	// A stalled result beat holds
	`AMAD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable({dir_x, dir_y, dir_z, zero_vector}))

	// Zero flag comes with an all-zero direction
	`AMAD_ASSERT_NOW(a_zero_dir, out_valid && zero_vector, dir_x == '0 && dir_y == '0 && dir_z == '0)

	// A unit vector always has a nonzero component
	`AMAD_ASSERT_NOW(a_unit_nonzero, out_valid && !zero_vector, dir_x != '0 || dir_y != '0 || dir_z != '0)

	// An accepted sample leaves the input side busy in the cycle after
	`AMAD_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready)

endmodule

bind accel_moving_average_direction_unit amad_chk u_amad_chk (.*);

// ===== tb/accel_moving_average_direction_unit_test.sv =====
`timescale 1ns / 1ps

module accel_moving_average_direction_unit_test;
	import amad_pkg::*;

	localparam int MAX_WINDOW   = 128;
	localparam int SAMPLE_BITS  = 16;
	localparam int RANDOM_ITEMS = 1000;
	localparam int LONG_HOLD    = 600;
	localparam int SETTLE       = 300;

	typedef struct {
		logic signed [SAMPLE_BITS-1:0] x;
		logic signed [SAMPLE_BITS-1:0] y;
		logic signed [SAMPLE_BITS-1:0] z;
	} sample_t;

	typedef struct {
		logic signed [DIR_BITS-1:0] dx;
		logic signed [DIR_BITS-1:0] dy;
		logic signed [DIR_BITS-1:0] dz;
		logic                       zero;
	} direction_t;

	// DUT ports
	logic                          clk         = 1'b0;
	logic                          arst_n      = 1'b0;
	logic                          cfg_valid   = 1'b0;
	logic                          cfg_ready;
	logic [WL_BITS-1:0]            window_len  = '0;
	logic                          in_valid    = 1'b0;
	logic                          in_ready;
	logic signed [SAMPLE_BITS-1:0] accel_x     = '0;
	logic signed [SAMPLE_BITS-1:0] accel_y     = '0;
	logic signed [SAMPLE_BITS-1:0] accel_z     = '0;
	logic                          out_valid;
	logic                          out_ready   = 1'b0;
	logic signed [DIR_BITS-1:0]    dir_x;
	logic signed [DIR_BITS-1:0]    dir_y;
	logic signed [DIR_BITS-1:0]    dir_z;
	logic                          zero_vector;

	// Predictor state: history ring, priming and window setting
	int          hist [MAX_WINDOW][3];
	int          seed_sample [3];
	int unsigned hist_ptr      = 0;
	int unsigned hist_count    = 0;
	bit          history_armed = 1'b0;
	int unsigned avg_len       = WL_RESET;

	// Traffic bookkeeping
	sample_t     tx_pending [$];
	direction_t  dir_expected [$];
	sample_t     tx_next;
	sample_t     last_gen        = '{0, 0, 0};
	int          tx_gap          = 0;
	int          tx_idle_max     = 0;
	int          rx_idle_max     = 0;
	int          rx_wait         = 0;
	int          rx_draw;
	int          long_hold_asked = 0;
	int          long_hold_done  = 0;
	int          samples_sent    = 0;
	int          results_seen    = 0;
	int          zero_results    = 0;
	int          cfg_writes      = 0;
	int          mismatches      = 0;

	accel_moving_average_direction_unit #(
		.MAX_WINDOW (MAX_WINDOW),
		.SAMPLE_BITS(SAMPLE_BITS)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.window_len (window_len),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.accel_x    (accel_x),
		.accel_y    (accel_y),
		.accel_z    (accel_z),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.dir_x      (dir_x),
		.dir_y      (dir_y),
		.dir_z      (dir_z),
		.zero_vector(zero_vector)
	);

	always #5 clk = ~clk;

	// Boxcar sum over the window, then unit direction in Q1.14
	function automatic void predict_direction(input logic signed [SAMPLE_BITS-1:0] sx,
			input logic signed [SAMPLE_BITS-1:0] sy, input logic signed [SAMPLE_BITS-1:0] sz);
		int                         cur [3];
		int unsigned                eff_len;
		int unsigned                slot;
		longint                     acc [3];
		longint unsigned            mag [3];
		bit                         neg [3];
		longint unsigned            peak;
		longint unsigned            sq_sum;
		longint unsigned            root;
		longint unsigned            cand;
		longint unsigned            quo;
		logic signed [DIR_BITS-1:0] d16 [3];
		direction_t                 res;
		int                         i;
		int                         k;
		int                         b;

		cur[0] = sx;
		cur[1] = sy;
		cur[2] = sz;
		eff_len = (avg_len == 0) ? 1 : ((avg_len > MAX_WINDOW) ? MAX_WINDOW : avg_len);

		// first sample after reset or a window write stands in for older history
		if (!history_armed) begin
			seed_sample   = cur;
			hist_count    = 0;
			history_armed = 1'b1;
		end

		for (i = 0; i < 3; i++)
			acc[i] = cur[i];
		for (k = 1; k < eff_len; k++) begin
			slot = (hist_ptr + MAX_WINDOW - k) % MAX_WINDOW;
			for (i = 0; i < 3; i++)
				acc[i] += (k <= hist_count) ? hist[slot][i] : seed_sample[i];
		end

		hist[hist_ptr] = cur;
		hist_ptr       = (hist_ptr + 1) % MAX_WINDOW;
		if (hist_count < MAX_WINDOW)
			hist_count++;

		peak = 0;
		for (i = 0; i < 3; i++) begin
			neg[i] = acc[i] < 0;
			mag[i] = neg[i] ? longint'(-acc[i]) : longint'(acc[i]);
			if (mag[i] > peak)
				peak = mag[i];
		end

		if (peak == 0) begin
			res.dx   = '0;
			res.dy   = '0;
			res.dz   = '0;
			res.zero = 1'b1;
		end else begin
			// bring the largest magnitude into [2^29, 2^30)
			while (peak >= (64'd1 << 30)) begin
				peak >>= 1;
				for (i = 0; i < 3; i++)
					mag[i] >>= 1;
			end
			while (peak < (64'd1 << 29)) begin
				peak <<= 1;
				for (i = 0; i < 3; i++)
					mag[i] <<= 1;
			end
			sq_sum = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];

			// floor square root, one bit at a time from the top
			root = 0;
			for (b = 31; b >= 0; b--) begin
				cand = root | (64'd1 << b);
				if (cand * cand <= sq_sum)
					root = cand;
			end

			// a * 16384 / r, rounded half up, capped at 1.0
			for (i = 0; i < 3; i++) begin
				quo = (mag[i] * 64'd32768 + root) / (64'd2 * root);
				if (quo > 64'd16384)
					quo = 64'd16384;
				d16[i] = quo[DIR_BITS-1:0];
				if (neg[i])
					d16[i] = -d16[i];
			end
			res.dx   = d16[0];
			res.dy   = d16[1];
			res.dz   = d16[2];
			res.zero = 1'b0;
		end
		dir_expected = {dir_expected, res};
	endfunction

	function automatic void report_field(input string field, input int exp_val,
			input int act_val);
		if (exp_val != act_val) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_val,
				act_val);
			mismatches++;
		end
	endfunction

	function automatic void queue_sample(input int x, input int y, input int z);
		sample_t s;
		s.x = x[SAMPLE_BITS-1:0];
		s.y = y[SAMPLE_BITS-1:0];
		s.z = z[SAMPLE_BITS-1:0];
		tx_pending = {tx_pending, s};
	endfunction

	// Random sample: full range, corner values, tiny values, cancels, repeats, single axis
	function automatic sample_t make_sample();
		sample_t s;
		int      corner [5];

		corner = '{-32768, 32767, 0, -1, 1};
		case ($urandom_range(0, 7))
			0, 1, 2: begin
				s.x = SAMPLE_BITS'($urandom);
				s.y = SAMPLE_BITS'($urandom);
				s.z = SAMPLE_BITS'($urandom);
			end
			3: begin
				s.x = SAMPLE_BITS'(corner[$urandom_range(0, 4)]);
				s.y = SAMPLE_BITS'(corner[$urandom_range(0, 4)]);
				s.z = SAMPLE_BITS'(corner[$urandom_range(0, 4)]);
			end
			4: begin
				s.x = SAMPLE_BITS'($urandom_range(0, 6) - 3);
				s.y = SAMPLE_BITS'($urandom_range(0, 6) - 3);
				s.z = SAMPLE_BITS'($urandom_range(0, 6) - 3);
			end
			5: begin
				s.x = -last_gen.x;
				s.y = -last_gen.y;
				s.z = -last_gen.z;
			end
			6: s = last_gen;
			default: begin
				s.x = '0;
				s.y = '0;
				s.z = '0;
				case ($urandom_range(0, 2))
					0: s.x = SAMPLE_BITS'($urandom);
					1: s.y = SAMPLE_BITS'($urandom);
					default: s.z = SAMPLE_BITS'($urandom);
				endcase
			end
		endcase
		last_gen = s;
		return s;
	endfunction

	// Wait until the sender is empty and every expected beat has come back;
	// checked at the falling edge so the rising-edge updates have settled
	task automatic drain_results();
		while (tx_pending.size() != 0 || in_valid || dir_expected.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_window(input logic [WL_BITS-1:0] wl);
		drain_results();
		window_len <= wl;
		cfg_valid  <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		avg_len       = wl;
		history_armed = 1'b0;
		cfg_writes++;
		cfg_valid <= 1'b0;
	endtask

	// Sender: one beat per pending sample, random gap after each
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			accel_x  <= '0;
			accel_y  <= '0;
			accel_z  <= '0;
			tx_gap   <= 0;
		end else begin
			if (in_valid && in_ready) begin
				predict_direction(accel_x, accel_y, accel_z);
				samples_sent++;
			end
			if (!in_valid || in_ready) begin
				if (tx_gap != 0) begin
					in_valid <= 1'b0;
					tx_gap   <= tx_gap - 1;
				end else if (tx_pending.size() != 0) begin
					tx_next  = tx_pending.pop_front();
					accel_x  <= tx_next.x;
					accel_y  <= tx_next.y;
					accel_z  <= tx_next.z;
					in_valid <= 1'b1;
					tx_gap   <= $urandom_range(0, tx_idle_max);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: check each beat, then hold off a random or long stretch
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_wait   <= 0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (zero_vector)
					zero_results++;
				if (dir_expected.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %0d %0d %0d %0b",
						$time, dir_x, dir_y, dir_z, zero_vector);
					mismatches++;
				end else begin
					report_field("dir_x", dir_expected[0].dx, dir_x);
					report_field("dir_y", dir_expected[0].dy, dir_y);
					report_field("dir_z", dir_expected[0].dz, dir_z);
					report_field("zero_vector", dir_expected[0].zero, zero_vector);
					void'(dir_expected.pop_front());
				end
			end

			if (long_hold_done != long_hold_asked) begin
				long_hold_done <= long_hold_asked;
				rx_wait        <= LONG_HOLD;
				out_ready      <= 1'b0;
			end else if (out_valid && out_ready) begin
				rx_draw = $urandom_range(0, rx_idle_max);
				rx_wait   <= rx_draw;
				out_ready <= (rx_draw == 0);
			end else if (rx_wait != 0) begin
				rx_wait   <= rx_wait - 1;
				out_ready <= (rx_wait == 1);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Stimulus and verdict
	initial begin
		int                 random_items;
		int                 phase;
		int                 n;
		int                 j;
		logic [WL_BITS-1:0] wl;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset window length, priming from the first sample
		queue_sample(32767, 32767, 32767);
		queue_sample(-32768, -32768, -32768);
		queue_sample(1, 0, 0);

		// single-sample window: zero vector, corners, small ratios
		write_window(8'd1);
		queue_sample(0, 0, 0);
		queue_sample(32767, -32768, 0);
		queue_sample(-1, 0, 0);
		queue_sample(0, 0, 1);
		queue_sample(-32768, 32767, -32768);
		queue_sample(3, 4, 0);

		// zero length acts as one
		write_window(8'd0);
		queue_sample(0, -32768, 0);
		queue_sample(12345, -6789, 100);

		// two-sample window: exact cancellation gives a zero vector
		write_window(8'd2);
		queue_sample(1000, -2000, 3000);
		queue_sample(-1000, 2000, -3000);
		queue_sample(5, 5, 5);

		// oversize length saturates at the ring depth
		write_window(8'd255);
		queue_sample(32767, 0, -32768);
		queue_sample(-32768, -32768, 32767);
		queue_sample(0, 0, 0);

		// random phases, each possibly with a new window setting
		random_items = 0;
		phase        = 0;
		while (random_items < RANDOM_ITEMS) begin
			case (phase)
				0: wl = 8'd128;
				1: wl = 8'd127;
				2: wl = 8'd129;
				default: begin
					case ($urandom_range(0, 9))
						0, 1, 2, 3: wl = WL_BITS'($urandom_range(1, 8));
						4: wl = WL_BITS'($urandom_range(0, 2));
						5, 6: wl = WL_BITS'($urandom_range(9, 64));
						7: wl = WL_BITS'($urandom_range(100, 128));
						default: wl = WL_BITS'($urandom_range(129, 255));
					endcase
				end
			endcase
			if (phase < 3 || $urandom_range(0, 3) != 0)
				write_window(wl);
			else
				drain_results();

			case ($urandom_range(0, 2))
				0: tx_idle_max = 0;
				1: tx_idle_max = 14;
				default: tx_idle_max = $urandom_range(0, 14);
			endcase
			case ($urandom_range(0, 2))
				0: rx_idle_max = 0;
				1: rx_idle_max = 14;
				default: rx_idle_max = $urandom_range(0, 14);
			endcase

			// long first phase wraps the ring at full window
			n = (phase == 0) ? 200 : $urandom_range(40, 100);
			for (j = 0; j < n; j++)
				tx_pending = {tx_pending, make_sample()};
			if (phase == 1 || phase == 6)
				long_hold_asked++;
			random_items += n;
			phase++;
		end

		drain_results();
		repeat (SETTLE) @(posedge clk);

		while (dir_expected.size() != 0) begin
			$display("%0t: missing result, expected %0d %0d %0d %0b, actual none", $time,
				dir_expected[0].dx, dir_expected[0].dy, dir_expected[0].dz,
				dir_expected[0].zero);
			void'(dir_expected.pop_front());
			mismatches++;
		end

		$display("Sent %0d samples over %0d window settings, checked %0d directions.",
			samples_sent, cfg_writes, results_seen);
		$display("Zero-vector results: %0d, mismatches: %0d.", zero_results, mismatches);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// Watchdog
	initial begin
		#15000000;
		$display("Timeout after %0d samples and %0d results.", samples_sent, results_seen);
		$display("FAILED: results differ");
		$finish;
	end

endmodule
